@@ rtl/pngsa_pkg.sv @@
package pngsa_pkg;

	localparam int NUM_AXES = 6;
	localparam int AXIS_W = 3;
	localparam int DATA_W = 16;
	localparam int GAIN_W = 32;
	localparam int PROD_W = GAIN_W + DATA_W;
	localparam int FRAME_W = 5;

	localparam int WARMUP_FRAMES_DEF = 30;
	localparam int AXES_PER_GROUP_DEF = 3;

	// 1.0 in Q4.12.
	localparam logic signed [DATA_W-1:0] FACTOR_RESET = 16'sd4096;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/pngsa_div.sv @@
module pngsa_div
	import pngsa_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] factor,
	input  logic        [DATA_W-1:0] divisor,
	output div_stat_t                stat,
	output logic signed [GAIN_W-1:0] quot
);

	localparam int CNT_W = $clog2(GAIN_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [GAIN_W-1:0] num_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic              neg_q;

	logic [DATA_W-1:0] mag;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   rem_nx;
	logic              ge;

	// The magnitude of the most negative factor is 0x8000, which still fits unsigned.
	assign mag = factor[DATA_W-1] ? DATA_W'(-factor) : DATA_W'(factor);

	always_comb begin
		rem_sh = {rem_q, num_q[GAIN_W-1]};
		ge = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	// Restoring division, one quotient bit per cycle; the quotient shifts into num_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			neg_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				num_q <= {mag, {(GAIN_W-DATA_W){1'b0}}};
				rem_q <= '0;
				den_q <= divisor;
				neg_q <= factor[DATA_W-1];
			end else if (busy_q) begin
				rem_q <= rem_nx[DATA_W-1:0];
				num_q <= {num_q[GAIN_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(GAIN_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot = neg_q ? $signed(-num_q) : $signed(num_q);

endmodule

@@ rtl/pngsa_scale.sv @@
module pngsa_scale
	import pngsa_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [GAIN_W-1:0] gain,
	input  logic signed [DATA_W-1:0] sample,
	output logic                     res_valid,
	output logic signed [DATA_W-1:0] res
);

	logic                     vld_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s2;
	logic signed [DATA_W-1:0] res_s2;

	logic signed [GAIN_W-1:0] shifted;

	// Dropping the low 16 bits of a two's complement product rounds toward minus infinity.
	assign shifted = prod_s1[PROD_W-1:DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			prod_s1 <= '0;
			res_s2 <= '0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			if (start) begin
				prod_s1 <= PROD_W'(gain) * PROD_W'(sample);
			end
			if (vld_s1) begin
				if (shifted > 32'sd32767) begin
					res_s2 <= 16'sh7fff;
				end else if (shifted < -32'sd32768) begin
					res_s2 <= 16'sh8000;
				end else begin
					res_s2 <= shifted[DATA_W-1:0];
				end
			end
		end
	end

	assign res_valid = vld_s2;
	assign res = res_s2;

endmodule

@@ rtl/peak_normalizing_gain_six_axis.sv @@
// Six-axis peak-tracking gain normalizer. Each item carries one head-pose sample (three
// positions, three rotations, signed Q4.12) and yields one item of scaled Q4.12 outputs.
// Axes are handled one after another by a single one-bit-per-cycle divider and one
// 32x16 multiplier: an axis without a new peak goes through the check, multiply and wait
// steps, and an axis with a new peak also runs the divider for all 32 quotient bits of
// its new gain. in_ready stays low while an item is being worked on. A finished item
// waits in the output register, and the next item may be accepted while it does.
module peak_normalizing_gain_six_axis
	import pngsa_pkg::*;
#(
	parameter int WARMUP_FRAMES = WARMUP_FRAMES_DEF,
	parameter int AXES_PER_GROUP = AXES_PER_GROUP_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic        [AXIS_W-1:0] cfg_index,
	input  logic        [DATA_W-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] pos_x,
	input  logic signed [DATA_W-1:0] pos_y,
	input  logic signed [DATA_W-1:0] pos_z,
	input  logic signed [DATA_W-1:0] rot_yaw,
	input  logic signed [DATA_W-1:0] rot_pitch,
	input  logic signed [DATA_W-1:0] rot_roll,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] out_x,
	output logic signed [DATA_W-1:0] out_y,
	output logic signed [DATA_W-1:0] out_z,
	output logic signed [DATA_W-1:0] out_yaw,
	output logic signed [DATA_W-1:0] out_pitch,
	output logic signed [DATA_W-1:0] out_roll
);

	localparam logic [FRAME_W-1:0] WARM_LIM = FRAME_W'(WARMUP_FRAMES);
	localparam logic [AXIS_W-1:0] GROUP_N = AXIS_W'(AXES_PER_GROUP);
	localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES-1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_MUL,
		ST_WAIT,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic        [AXIS_W-1:0] axis_q;
	logic                     warm_q;
	logic       [FRAME_W-1:0] frame_q;
	logic                     div_start_q;
	logic                     scl_start_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] factor_q [NUM_AXES];
	logic        [DATA_W-1:0] peak_q   [NUM_AXES];
	logic signed [GAIN_W-1:0] gain_q   [NUM_AXES];
	logic signed [DATA_W-1:0] sample_q [NUM_AXES];
	logic signed [DATA_W-1:0] res_q    [NUM_AXES];
	logic signed [DATA_W-1:0] out_q    [NUM_AXES];

	div_stat_t                div_stat;
	logic signed [GAIN_W-1:0] div_quot;
	logic                     scl_valid;
	logic signed [DATA_W-1:0] scl_res;

	logic signed [DATA_W-1:0] cur_s;
	logic        [DATA_W-1:0] cur_m;
	logic                     take;

	always_comb begin
		cur_s = sample_q[axis_q];
		cur_m = cur_s[DATA_W-1] ? DATA_W'(-cur_s) : DATA_W'(cur_s);
		// Position axes follow any nonzero magnitude during warm-up.
		take = (cur_m > peak_q[axis_q]) ||
			((axis_q < GROUP_N) && warm_q && (cur_m != '0));
	end

	pngsa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.factor  (factor_q[axis_q]),
		.divisor (peak_q[axis_q]),
		.stat    (div_stat),
		.quot    (div_quot)
	);

	pngsa_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scl_start_q),
		.gain      (gain_q[axis_q]),
		.sample    (sample_q[axis_q]),
		.res_valid (scl_valid),
		.res       (scl_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= '0;
			warm_q <= 1'b0;
			frame_q <= '0;
			div_start_q <= 1'b0;
			scl_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				factor_q[i] <= FACTOR_RESET;
				peak_q[i] <= '0;
				gain_q[i] <= '0;
				sample_q[i] <= '0;
				res_q[i] <= '0;
				out_q[i] <= '0;
			end
		end else begin
			div_start_q <= 1'b0;
			scl_start_q <= 1'b0;
			if (cfg_we && (cfg_index < LAST_AXIS + 1'b1)) begin
				factor_q[cfg_index] <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sample_q[0] <= pos_x;
						sample_q[1] <= pos_y;
						sample_q[2] <= pos_z;
						sample_q[3] <= rot_yaw;
						sample_q[4] <= rot_pitch;
						sample_q[5] <= rot_roll;
						warm_q <= frame_q < WARM_LIM;
						if (frame_q < WARM_LIM) begin
							frame_q <= frame_q + 1'b1;
						end
						axis_q <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (take) begin
						peak_q[axis_q] <= cur_m;
						div_start_q <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						gain_q[axis_q] <= div_quot;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					scl_start_q <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (scl_valid) begin
						res_q[axis_q] <= scl_res;
						if (axis_q == LAST_AXIS) begin
							state_q <= ST_DONE;
						end else begin
							axis_q <= axis_q + 1'b1;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_DONE: begin
					// Hand over once the output register is free or being emptied.
					if (!out_valid_q || out_ready) begin
						for (int i = 0; i < NUM_AXES; i++) begin
							out_q[i] <= res_q[i];
						end
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_x = out_q[0];
	assign out_y = out_q[1];
	assign out_z = out_q[2];
	assign out_yaw = out_q[3];
	assign out_pitch = out_q[4];
	assign out_roll = out_q[5];

	a_div_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> (state_q == ST_DIV && !div_stat.busy))
		else $error("divider started outside of a division step");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_stat.busy)
		else $error("divider busy while a new item can be accepted");

	a_scale_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		scl_valid |-> (state_q == ST_WAIT))
		else $error("scaled result arrived outside of the wait step");

	a_handover: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!out_valid_q || out_ready)) |=>
		(out_valid_q && state_q == ST_IDLE))
		else $error("finished item not moved to the output register");

endmodule
